// ----- hdl/relop_keyword_id_number_lexer_assert.svh -----
// Assertion helpers for the lexer
`ifndef RELOP_KEYWORD_ID_NUMBER_LEXER_ASSERT_SVH
`define RELOP_KEYWORD_ID_NUMBER_LEXER_ASSERT_SVH

// same-cycle implication
`define RKL_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RKL_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/rkl_pkg.sv -----
package rkl_pkg;

	localparam int POS_BITS_DEF = 16;
	localparam int SAT_W        = 32;
	localparam int Q_DEPTH      = 4;

	// characters the scanner looks at
	localparam logic [7:0] CH_HASH  = 8'd35;
	localparam logic [7:0] CH_E     = 8'd69;
	localparam logic [7:0] CH_DOT   = 8'd46;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_LT    = 8'd60;
	localparam logic [7:0] CH_EQ    = 8'd61;
	localparam logic [7:0] CH_GT    = 8'd62;
	localparam logic [7:0] CH_LA    = 8'd97;
	localparam logic [7:0] CH_LZ    = 8'd122;
	localparam logic [7:0] CH_UA    = 8'd65;
	localparam logic [7:0] CH_UZ    = 8'd90;
	localparam logic [7:0] CH_D0    = 8'd48;
	localparam logic [7:0] CH_D9    = 8'd57;
	localparam logic [7:0] CH_SP    = 8'd32;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_I     = 8'd105;
	localparam logic [7:0] CH_F     = 8'd102;
	localparam logic [7:0] CH_T     = 8'd116;
	localparam logic [7:0] CH_H     = 8'd104;
	localparam logic [7:0] CH_LE    = 8'd101;
	localparam logic [7:0] CH_N     = 8'd110;
	localparam logic [7:0] CH_L     = 8'd108;
	localparam logic [7:0] CH_S     = 8'd115;
	localparam logic [7:0] CH_NUL   = 8'd0;

	typedef enum logic [3:0] {
		S_START, S_LT, S_GT, S_ID, S_KIF, S_KTHEN, S_KELSE,
		S_NINT, S_NDOT, S_NFRAC, S_NE, S_NESIGN, S_NEXP
	} scan_state_t;

	typedef enum logic [2:0] {
		K_RELOP, K_IF, K_THEN, K_ELSE, K_ID, K_NUM, K_ERR, K_END
	} kind_t;

	typedef enum logic [2:0] {
		R_LT, R_LE, R_NE, R_EQ, R_GT, R_GE
	} relop_t;

	typedef struct packed {
		kind_t       kind;
		relop_t      relop;
		logic [15:0] start;
		logic [15:0] len;
	} token_t;

	// everything one character produces: up to two tokens, a before b
	typedef struct packed {
		logic   va;
		logic   vb;
		token_t a;
		token_t b;
	} rec_t;

	function automatic logic is_letter(input logic [7:0] c);
		return c inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ]};
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[CH_D0:CH_D9]};
	endfunction

	// keyword spelling: k 0 if, 1 then, 2 else
	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
		logic [7:0] r;
		r = CH_NUL;
		case (k)
			2'd0: begin
				case (idx)
					3'd0: r = CH_I;
					3'd1: r = CH_F;
					default: r = CH_NUL;
				endcase
			end
			2'd1: begin
				case (idx)
					3'd0: r = CH_T;
					3'd1: r = CH_H;
					3'd2: r = CH_LE;
					3'd3: r = CH_N;
					default: r = CH_NUL;
				endcase
			end
			2'd2: begin
				case (idx)
					3'd0: r = CH_LE;
					3'd1: r = CH_L;
					3'd2: r = CH_S;
					3'd3: r = CH_LE;
					default: r = CH_NUL;
				endcase
			end
			default: r = CH_NUL;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] kw_len(input logic [1:0] k);
		return (k == 2'd0) ? 3'd2 : 3'd4;
	endfunction

	function automatic logic [15:0] sat16(input logic [SAT_W-1:0] v);
		return (v[SAT_W-1:16] != '0) ? 16'hFFFF : v[15:0];
	endfunction

endpackage

// ----- hdl/rkl_char_if.sv -----
interface rkl_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source(output valid, output char_code, input ready);
	modport sink(input valid, input char_code, output ready);
endinterface

// ----- hdl/rkl_tok_if.sv -----
interface rkl_tok_if;
	logic        valid;
	logic        ready;
	logic [2:0]  token_kind;
	logic [2:0]  relop_code;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic        last_of_run;

	modport source(output valid, output token_kind, output relop_code,
		output token_start, output token_length, output last_of_run, input ready);
	modport sink(input valid, input token_kind, input relop_code,
		input token_start, input token_length, input last_of_run, output ready);
endinterface

// ----- hdl/rkl_front.sv -----
module rkl_front import rkl_pkg::*; #(
	parameter int POS_BITS = POS_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rkl_char_if.sink    chars,
	output rec_t        rec,
	output logic        rec_valid,
	input  logic        rec_ready
);

	scan_state_t         state_q, state_d;
	logic [2:0]          prog_q, prog_d;
	logic [POS_BITS-1:0] pos_q, pos_d;
	logic [POS_BITS-1:0] start_q, start_d;
	logic                accept;

	assign chars.ready = rec_ready;
	assign accept      = chars.valid && rec_ready;

	// scanner: one transition per character, pending token closed first
	always_comb begin
		logic [7:0]          c;
		logic [POS_BITS-1:0] pdiff;
		logic [15:0]         plen, pstart, sstart;
		logic [1:0]          kidx;
		logic                alnum, consumed, restart;
		token_t              ta, tb;
		logic                va, vb;

		c        = chars.char_code;
		pdiff    = pos_q - start_q;
		plen     = sat16(SAT_W'(pdiff));
		pstart   = sat16(SAT_W'(pos_q));
		sstart   = sat16(SAT_W'(start_q));
		kidx     = 2'(4'(state_q) - 4'(S_KIF));
		alnum    = is_letter(c) || is_digit(c);
		consumed = 1'b0;
		restart  = 1'b0;
		va       = 1'b0;
		vb       = 1'b0;
		ta       = '{kind: K_RELOP, relop: R_LT, start: sstart, len: plen};
		tb       = '{kind: K_RELOP, relop: R_LT, start: pstart, len: 16'd1};
		state_d  = state_q;
		prog_d   = prog_q;
		start_d  = start_q;
		pos_d    = pos_q;

		// continue the pending token; on a close, state drops back to start
		case (state_q)
			S_START: ;
			S_LT: begin
				if (c == CH_EQ || c == CH_GT) begin
					va       = 1'b1;
					ta.relop = (c == CH_EQ) ? R_LE : R_NE;
					ta.len   = 16'd2;
					consumed = 1'b1;
				end else begin
					va = 1'b1;
				end
				state_d = S_START;
				prog_d  = '0;
			end
			S_GT: begin
				va       = 1'b1;
				if (c == CH_EQ) begin
					ta.relop = R_GE;
					ta.len   = 16'd2;
					consumed = 1'b1;
				end else begin
					ta.relop = R_GT;
				end
				state_d = S_START;
				prog_d  = '0;
			end
			S_ID: begin
				if (alnum) begin
					consumed = 1'b1;
				end else begin
					va      = 1'b1;
					ta.kind = K_ID;
					state_d = S_START;
					prog_d  = '0;
				end
			end
			S_KIF, S_KTHEN, S_KELSE: begin
				if (alnum) begin
					consumed = 1'b1;
					if (prog_q < kw_len(kidx) && c == kw_char(kidx, prog_q)) begin
						prog_d = prog_q + 3'd1;
					end else begin
						state_d = S_ID;
						prog_d  = '0;
					end
				end else begin
					va      = 1'b1;
					ta.kind = (prog_q == kw_len(kidx)) ? kind_t'(3'(kidx) + 3'd1) : K_ID;
					state_d = S_START;
					prog_d  = '0;
				end
			end
			S_NINT, S_NFRAC: begin
				if (is_digit(c)) begin
					consumed = 1'b1;
				end else if (c == CH_DOT && state_q == S_NINT) begin
					consumed = 1'b1;
					state_d  = S_NDOT;
				end else if (c == CH_E) begin
					consumed = 1'b1;
					state_d  = S_NE;
				end else begin
					va      = 1'b1;
					ta.kind = K_NUM;
					state_d = S_START;
					prog_d  = '0;
				end
			end
			S_NDOT: begin
				if (is_digit(c)) begin
					consumed = 1'b1;
					state_d  = S_NFRAC;
				end else begin
					va      = 1'b1;
					ta.kind = K_ERR;
					state_d = S_START;
					prog_d  = '0;
				end
			end
			S_NE: begin
				if (c == CH_PLUS || c == CH_MINUS) begin
					consumed = 1'b1;
					state_d  = S_NESIGN;
				end else if (is_digit(c)) begin
					consumed = 1'b1;
					state_d  = S_NEXP;
				end else begin
					va      = 1'b1;
					ta.kind = K_ERR;
					state_d = S_START;
					prog_d  = '0;
				end
			end
			S_NESIGN: begin
				if (is_digit(c)) begin
					consumed = 1'b1;
					state_d  = S_NEXP;
				end else begin
					va      = 1'b1;
					ta.kind = K_ERR;
					state_d = S_START;
					prog_d  = '0;
				end
			end
			S_NEXP: begin
				if (is_digit(c)) begin
					consumed = 1'b1;
				end else begin
					va      = 1'b1;
					ta.kind = K_NUM;
					state_d = S_START;
					prog_d  = '0;
				end
			end
			default: begin
				state_d = S_START;
				prog_d  = '0;
			end
		endcase

		// start a new token with a character the old one did not take
		if (!consumed && !(c == CH_SP || c == CH_TAB || c == CH_NL)) begin
			if (c == CH_HASH) begin
				vb      = 1'b1;
				tb.kind = K_END;
				restart = 1'b1;
			end else begin
				start_d = pos_q;
				prog_d  = '0;
				if (c == CH_LT) begin
					state_d = S_LT;
				end else if (c == CH_GT) begin
					state_d = S_GT;
				end else if (c == CH_EQ) begin
					vb       = 1'b1;
					tb.relop = R_EQ;
				end else if (is_letter(c)) begin
					if (c == CH_I) begin
						state_d = S_KIF;
						prog_d  = 3'd1;
					end else if (c == CH_T) begin
						state_d = S_KTHEN;
						prog_d  = 3'd1;
					end else if (c == CH_LE) begin
						state_d = S_KELSE;
						prog_d  = 3'd1;
					end else begin
						state_d = S_ID;
					end
				end else if (is_digit(c)) begin
					state_d = S_NINT;
				end else begin
					vb      = 1'b1;
					tb.kind = K_ERR;
				end
			end
		end

		// position count, saturating; '#' restarts it
		if (restart) begin
			state_d = S_START;
			prog_d  = '0;
			pos_d   = '0;
			start_d = '0;
		end else if (pos_q != '1) begin
			pos_d = pos_q + 1'b1;
		end

		rec       = '{va: va, vb: vb, a: ta, b: tb};
		rec_valid = accept && (va || vb);
	end

	// scanner registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_START;
			prog_q  <= '0;
			pos_q   <= '0;
			start_q <= '0;
		end else if (accept) begin
			state_q <= state_d;
			prog_q  <= prog_d;
			pos_q   <= pos_d;
			start_q <= start_d;
		end
	end

endmodule

// ----- hdl/rkl_queue.sv -----
module rkl_queue import rkl_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rec_t                           wr_rec,
	input  logic                           push,
	output logic                           not_full,
	output rec_t                           head,
	output logic                           head_valid,
	input  logic                           pop,
	output logic [$clog2(Q_DEPTH+1)-1:0]   level
);

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	rec_t             mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign not_full   = (cnt_q != CNT_W'(Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign level      = cnt_q;
	assign do_push    = push && not_full;
	assign do_pop     = pop && head_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/rkl_back.sv -----
module rkl_back import rkl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  rec_t        head,
	input  logic        head_valid,
	output logic        pop,
	rkl_tok_if.source   tokens
);

	logic   valid_q;
	logic   half_q;
	token_t tok_q;
	logic   last_q;
	logic   load, send_a, last;
	token_t sel;

	// pick the next token of the head record
	assign load   = head_valid && (!valid_q || tokens.ready);
	assign send_a = !half_q && head.va;
	assign sel    = send_a ? head.a : head.b;
	assign last   = send_a ? !head.vb : 1'b1;
	assign pop    = load && last;

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q  <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				half_q  <= !last;
			end else if (tokens.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			tok_q  <= sel;
			last_q <= last;
		end
	end

	assign tokens.valid        = valid_q;
	assign tokens.token_kind   = tok_q.kind;
	assign tokens.relop_code   = tok_q.relop;
	assign tokens.token_start  = tok_q.start;
	assign tokens.token_length = tok_q.len;
	assign tokens.last_of_run  = last_q;

endmodule

// ----- hdl/relop_keyword_id_number_lexer.sv -----
// Channel  Dir  Fields                                          Accepted when
// chars    in   char_code                                       valid && ready
// tokens   out  token_kind relop_code token_start token_length  valid && ready
//               last_of_run
// One character a cycle unless the queue is full; a character's two tokens go out in turn.
// A token passes from the scanner through the record queue into the output register.
// The single output register and a four-record queue between scanner and output set the rate.
// arst_n clears the scanner to its start state, the queue and the output valid.
// chars stalls only while the queue is full; the scanner keeps going while tokens waits.
module relop_keyword_id_number_lexer import rkl_pkg::*; #(
	parameter int POS_BITS = POS_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rkl_char_if.sink  chars,
	rkl_tok_if.source tokens
);

	rec_t                               f_rec;
	logic                               f_valid;
	logic                               q_not_full;
	rec_t                               q_head;
	logic                               q_head_valid;
	logic                               q_pop;
	logic [$clog2(Q_DEPTH+1)-1:0]       q_level;

	// scanner
	rkl_front #(.POS_BITS(POS_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.chars     (chars),
		.rec       (f_rec),
		.rec_valid (f_valid),
		.rec_ready (q_not_full)
	);

	// record queue
	rkl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_rec     (f_rec),
		.push       (f_valid),
		.not_full   (q_not_full),
		.head       (q_head),
		.head_valid (q_head_valid),
		.pop        (q_pop),
		.level      (q_level)
	);

	// token output
	rkl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.head_valid (q_head_valid),
		.pop        (q_pop),
		.tokens     (tokens)
	);

	`include "relop_keyword_id_number_lexer_assert.svh"

	`RKL_ASSERT_IMP(a_relop_code_zero, clk, arst_n, tokens.valid && tokens.token_kind != K_RELOP, tokens.relop_code == R_LT, "relop code set on a non-relop token")
	`RKL_ASSERT_IMP(a_end_is_last, clk, arst_n, tokens.valid && tokens.token_kind == K_END, tokens.last_of_run, "end marker not last of its character")
	`RKL_ASSERT_IMP(a_stall_only_full, clk, arst_n, !chars.ready, q_level == $bits(q_level)'(Q_DEPTH), "input stalled with room in queue")
	`RKL_ASSERT_NEXT(a_end_queued, clk, arst_n, chars.valid && chars.ready && chars.char_code == CH_HASH, q_level != '0, "end marker record missing from queue")

endmodule

// ----- test/lexer_token_checker.sv -----
`timescale 1ns / 100ps
// Watches both channels, predicts the token stream from the accepted characters
// and compares every accepted token with the oldest prediction.
module lexer_token_checker import rkl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	rkl_char_if  chars,
	rkl_tok_if   tokens,
	output int   mismatches,
	output int   tokens_due
);

	typedef struct {
		kind_t       kind;
		relop_t      relop;
		logic [15:0] start;
		logic [15:0] len;
		logic        last;
	} lex_tok_t;

	string kw_word [3] = '{"if", "then", "else"};

	lex_tok_t    tokens_due_q [$];
	lex_tok_t    step_toks [$];
	scan_state_t st;
	logic [2:0]  kw_prog;
	logic [15:0] pos;
	logic [15:0] tok_start;

	function automatic logic letter_char(input logic [7:0] c);
		return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
	endfunction

	function automatic logic digit_char(input logic [7:0] c);
		return c >= CH_D0 && c <= CH_D9;
	endfunction

	task automatic emit_tok(input kind_t k, input relop_t r, input logic [15:0] s,
		input logic [15:0] l);
		lex_tok_t t;
		t.kind = k;
		t.relop = r;
		t.start = s;
		t.len = l;
		t.last = 1'b0;
		step_toks = {step_toks, t};
	endtask

	// pending token ends before p; p itself is not part of it
	task automatic close_tok(input kind_t k, input relop_t r, input logic [15:0] p);
		emit_tok(k, r, tok_start, p - tok_start);
		st = S_START;
		kw_prog = '0;
	endtask

	// one character in, zero to two tokens out (relop field is zero unless relop)
	task automatic scan_char(input logic [7:0] c);
		logic [15:0] p;
		logic        taken;
		logic        restart;
		int          k;
		p = pos;
		taken = 1'b0;
		restart = 1'b0;
		step_toks.delete();

		// feed a pending token first
		case (st)
			S_START: ;
			S_LT: begin
				if (c == CH_EQ || c == CH_GT) begin
					emit_tok(K_RELOP, (c == CH_EQ) ? R_LE : R_NE, tok_start, 16'd2);
					st = S_START;
					taken = 1'b1;
				end else
					close_tok(K_RELOP, R_LT, p);
			end
			S_GT: begin
				if (c == CH_EQ) begin
					emit_tok(K_RELOP, R_GE, tok_start, 16'd2);
					st = S_START;
					taken = 1'b1;
				end else
					close_tok(K_RELOP, R_GT, p);
			end
			S_ID: begin
				if (letter_char(c) || digit_char(c))
					taken = 1'b1;
				else
					close_tok(K_ID, R_LT, p);
			end
			S_KIF, S_KTHEN, S_KELSE: begin
				k = int'(st) - int'(S_KIF);
				if (letter_char(c) || digit_char(c)) begin
					if (kw_prog < kw_word[k].len() && c == kw_word[k][kw_prog])
						kw_prog++;
					else begin
						st = S_ID;
						kw_prog = '0;
					end
					taken = 1'b1;
				end else if (kw_prog == kw_word[k].len())
					close_tok(kind_t'(int'(K_IF) + k), R_LT, p);
				else
					close_tok(K_ID, R_LT, p);
			end
			S_NINT, S_NFRAC: begin
				if (digit_char(c))
					taken = 1'b1;
				else if (c == CH_DOT && st == S_NINT) begin
					st = S_NDOT;
					taken = 1'b1;
				end else if (c == CH_E) begin
					st = S_NE;
					taken = 1'b1;
				end else
					close_tok(K_NUM, R_LT, p);
			end
			S_NDOT: begin
				if (digit_char(c)) begin
					st = S_NFRAC;
					taken = 1'b1;
				end else
					close_tok(K_ERR, R_LT, p);
			end
			S_NE: begin
				if (c == CH_PLUS || c == CH_MINUS) begin
					st = S_NESIGN;
					taken = 1'b1;
				end else if (digit_char(c)) begin
					st = S_NEXP;
					taken = 1'b1;
				end else
					close_tok(K_ERR, R_LT, p);
			end
			S_NESIGN: begin
				if (digit_char(c)) begin
					st = S_NEXP;
					taken = 1'b1;
				end else
					close_tok(K_ERR, R_LT, p);
			end
			S_NEXP: begin
				if (digit_char(c))
					taken = 1'b1;
				else
					close_tok(K_NUM, R_LT, p);
			end
			default: begin
				st = S_START;
				kw_prog = '0;
			end
		endcase

		// retracted or fresh character starts from the start state
		if (!taken) begin
			if (c == CH_SP || c == CH_TAB || c == CH_NL)
				;
			else if (c == CH_HASH) begin
				emit_tok(K_END, R_LT, p, 16'd1);
				restart = 1'b1;
			end else begin
				tok_start = p;
				kw_prog = '0;
				if (c == CH_LT)
					st = S_LT;
				else if (c == CH_GT)
					st = S_GT;
				else if (c == CH_EQ)
					emit_tok(K_RELOP, R_EQ, p, 16'd1);
				else if (letter_char(c)) begin
					if (c == CH_I)
						st = S_KIF;
					else if (c == CH_T)
						st = S_KTHEN;
					else if (c == CH_LE)
						st = S_KELSE;
					else
						st = S_ID;
					if (st != S_ID)
						kw_prog = 3'd1;
				end else if (digit_char(c))
					st = S_NINT;
				else
					emit_tok(K_ERR, R_LT, p, 16'd1);
			end
		end

		// position restarts on the end marker, saturates otherwise
		if (restart) begin
			st = S_START;
			kw_prog = '0;
			pos = '0;
			tok_start = '0;
		end else if (pos != 16'hFFFF)
			pos++;

		if (step_toks.size() > 0)
			step_toks[step_toks.size() - 1].last = 1'b1;
		foreach (step_toks[i])
			tokens_due_q = {tokens_due_q, step_toks[i]};
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatches++;
		$display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	task automatic check_token();
		lex_tok_t e;
		if (tokens_due_q.size() == 0) begin
			report_mismatch("token with nothing expected", 32'(tokens.token_kind), 0);
			return;
		end
		e = tokens_due_q.pop_front();
		if (tokens.token_kind !== e.kind)
			report_mismatch("token_kind", 32'(tokens.token_kind), 32'(e.kind));
		if (tokens.relop_code !== e.relop)
			report_mismatch("relop_code", 32'(tokens.relop_code), 32'(e.relop));
		if (tokens.token_start !== e.start)
			report_mismatch("token_start", 32'(tokens.token_start), 32'(e.start));
		if (tokens.token_length !== e.len)
			report_mismatch("token_length", 32'(tokens.token_length), 32'(e.len));
		if (tokens.last_of_run !== e.last)
			report_mismatch("last_of_run", 32'(tokens.last_of_run), 32'(e.last));
	endtask

	// predict on accepted characters, compare on accepted tokens
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st = S_START;
			kw_prog = '0;
			pos = '0;
			tok_start = '0;
			tokens_due_q.delete();
			tokens_due = 0;
			mismatches = 0;
		end else begin
			if (chars.valid && chars.ready)
				scan_char(chars.char_code);
			if (tokens.valid && tokens.ready)
				check_token();
			tokens_due = tokens_due_q.size();
		end
	end

endmodule

// ----- test/tb_relop_keyword_id_number_lexer.sv -----
`timescale 1ns / 100ps
module tb_relop_keyword_id_number_lexer import rkl_pkg::*;;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_CHARS = 170;

	logic       clk;
	logic       arst_n;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         hold_req = 0;
	int         hold_seen = 0;
	int         hold_left = 0;
	int         quiet_cycles = 0;
	int         mismatches;
	int         tokens_due;
	logic [7:0] char_text [$];

	rkl_char_if chars_if();
	rkl_tok_if  tok_if();

	relop_keyword_id_number_lexer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.tokens (tok_if)
	);

	lexer_token_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars_if),
		.tokens     (tok_if),
		.mismatches (mismatches),
		.tokens_due (tokens_due)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// token receiver: random stalls, plus a long hold-off on request
	initial begin
		tok_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				tok_if.ready <= 1'b0;
			end else
				tok_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog: too long without any item moving
	always @(posedge clk) begin
		if ((chars_if.valid && chars_if.ready) || (tok_if.valid && tok_if.ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	function automatic logic [7:0] rand_letter();
		return $urandom_range(1) ? 8'(CH_LA + $urandom_range(25)) : 8'(CH_UA + $urandom_range(25));
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'(CH_D0 + $urandom_range(9));
	endfunction

	// append one character to the pending text
	function automatic void add_char(input logic [7:0] c);
		char_text = {char_text, c};
	endfunction

	function automatic void add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i]);
	endfunction

	function automatic void add_digits(input int n);
		for (int i = 0; i < n; i++)
			add_char(rand_digit());
	endfunction

	function automatic void add_alnum(input int n);
		for (int i = 0; i < n; i++)
			add_char($urandom_range(2) ? rand_letter() : rand_digit());
	endfunction

	// keywords, near-keywords and plain identifiers
	function automatic void add_word();
		string kw [3] = '{"if", "then", "else"};
		int    k;
		k = $urandom_range(2);
		case ($urandom_range(6))
			0, 1, 2: add_str(kw[k]);
			3: add_str(kw[k].substr(0, $urandom_range(kw[k].len() - 2)));
			4: begin
				add_str(kw[k]);
				add_alnum(1 + $urandom_range(2));
			end
			5: add_str(kw[k].toupper());
			default: begin
				add_char(rand_letter());
				add_alnum($urandom_range(5));
			end
		endcase
	endfunction

	// numbers; dropped digit groups make broken ones
	function automatic void add_number();
		add_digits(1 + $urandom_range(3));
		if ($urandom_range(1)) begin
			add_char(CH_DOT);
			if ($urandom_range(7))
				add_digits(1 + $urandom_range(2));
		end
		if ($urandom_range(2) == 0) begin
			add_char(CH_E);
			case ($urandom_range(2))
				0: add_char(CH_PLUS);
				1: add_char(CH_MINUS);
				default: ;
			endcase
			if ($urandom_range(7))
				add_digits(1 + $urandom_range(2));
		end
	endfunction

	function automatic void add_relop();
		string ops [6] = '{"<", "<=", "<>", "=", ">", ">="};
		add_str(ops[$urandom_range(5)]);
	endfunction

	// mostly well-formed tokens, some noise and stray punctuation
	function automatic void make_text(input int n);
		int r;
		while (char_text.size() < n) begin
			r = $urandom_range(99);
			if (r < 30)
				add_word();
			else if (r < 55)
				add_number();
			else if (r < 75)
				add_relop();
			else if (r < 85)
				add_char(8'($urandom_range(255)));
			else if (r < 91)
				add_char(CH_HASH);
			else
				case ($urandom_range(3))
					0: add_char(CH_DOT);
					1: add_char(CH_PLUS);
					2: add_char(CH_MINUS);
					default: add_char(CH_E);
				endcase
			case ($urandom_range(9))
				0, 1, 2, 3: add_char(CH_SP);
				4: add_char(CH_TAB);
				5: add_char(CH_NL);
				default: ;
			endcase
		end
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_char(input logic [7:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			chars_if.valid <= 1'b0;
			@(negedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.char_code <= c;
		@(posedge clk);
		while (!chars_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_text();
		foreach (char_text[i])
			send_char(char_text[i]);
		char_text.delete();
	endtask

	// sender pauses until every predicted token has come out
	task automatic wait_drained();
		chars_if.valid <= 1'b0;
		@(negedge clk);
		while (tokens_due != 0)
			@(negedge clk);
	endtask

	initial begin
		chars_if.valid = 1'b0;
		chars_if.char_code = 8'd0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: every relop but a lone '=', keywords, broken numbers, byte extremes, end marker
		add_str("if<=then>else<9.5E+2>=1.E7E-x<>\t\n");
		add_char(8'hFF);
		add_char(8'h00);
		add_char(CH_HASH);
		send_text();
		wait_drained();

		// random phases with different idle/stall mixes
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 71;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 71;
				end
				default: begin
					send_idle_pct = 20;
					recv_stall_pct = 20;
				end
			endcase
			make_text(PHASE_CHARS);
			send_text();
			wait_drained();
		end

		// long receiver hold-off while characters keep coming: input must stall
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req++;
		make_text(40);
		send_text();

		wait_drained();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && tokens_due == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
